// ===== rtl/fss_pkg.sv =====
// Shared constants and types for the fuzzy signature scanner.
package fss_pkg;

    localparam int PATTERN_LEN = 32;
    localparam int HIST_DEPTH = PATTERN_LEN - 1;
    localparam int BYTE_W = 8;
    localparam int CNT_W = 25;
    localparam int OFFSET_W = 24;
    localparam int THRESH_W = 6;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int WORD3_W = 56;

    localparam logic [CNT_W-1:0] MAX_REGION_BYTES = CNT_W'(25'd16777216);
    localparam logic [CNT_W-1:0] FULL_WINDOW_IDX = CNT_W'(HIST_DEPTH);

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD0 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD1 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD2 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD3 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LAST_BYTE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 3'd5;

    typedef logic [HIST_DEPTH-1:0][BYTE_W-1:0] hist_t;

    typedef struct packed {
        hist_t sig;
        logic [BYTE_W-1:0] last_byte;
        logic [THRESH_W-1:0] threshold;
    } cfg_t;

endpackage

// ===== rtl/fss_cfg.sv =====
// Configuration registers: signature words, last signature byte, threshold.
module fss_cfg (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_write,
    input  logic [fss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fss_pkg::CFG_DATA_W-1:0] cfg_data,
    output fss_pkg::cfg_t cfg
);

    logic [fss_pkg::CFG_DATA_W-1:0] word0_reg;
    logic [fss_pkg::CFG_DATA_W-1:0] word1_reg;
    logic [fss_pkg::CFG_DATA_W-1:0] word2_reg;
    logic [fss_pkg::WORD3_W-1:0] word3_reg;
    logic [fss_pkg::BYTE_W-1:0] last_byte_reg;
    logic [fss_pkg::THRESH_W-1:0] threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word0_reg <= '0;
            word1_reg <= '0;
            word2_reg <= '0;
            word3_reg <= '0;
            last_byte_reg <= '0;
            threshold_reg <= fss_pkg::THRESH_W'(31);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                fss_pkg::REG_PATTERN_WORD0: word0_reg <= cfg_data;
                fss_pkg::REG_PATTERN_WORD1: word1_reg <= cfg_data;
                fss_pkg::REG_PATTERN_WORD2: word2_reg <= cfg_data;
                fss_pkg::REG_PATTERN_WORD3: word3_reg <= cfg_data[fss_pkg::WORD3_W-1:0];
                fss_pkg::REG_LAST_BYTE: last_byte_reg <= cfg_data[fss_pkg::BYTE_W-1:0];
                fss_pkg::REG_THRESHOLD: threshold_reg <= cfg_data[fss_pkg::THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.sig = {word3_reg, word2_reg, word1_reg, word0_reg};
    assign cfg.last_byte = last_byte_reg;
    assign cfg.threshold = threshold_reg;

endmodule

// ===== rtl/fss_count.sv =====
// Window compare: counts equal byte positions and checks the threshold.
module fss_count (
    input  fss_pkg::hist_t window,
    input  logic [fss_pkg::BYTE_W-1:0] data_byte,
    input  fss_pkg::cfg_t cfg,
    output logic hit
);

    logic [fss_pkg::PATTERN_LEN-1:0] eq;
    logic [fss_pkg::THRESH_W-1:0] count;

    always_comb
    begin
        for (int j = 0; j < fss_pkg::HIST_DEPTH; j++)
        begin
            eq[j] = (window[fss_pkg::HIST_DEPTH-1-j] == cfg.sig[j]);
        end
        eq[fss_pkg::PATTERN_LEN-1] = (data_byte == cfg.last_byte);
    end

    assign count = fss_pkg::THRESH_W'($countones(eq));
    assign hit = (count >= cfg.threshold);

endmodule

// ===== rtl/fuzzy_signature_scan.sv =====
// A word accepted into the input register passes the window compare into the result register.
// Throughput: one input word per cycle, but a word with a result waits while the output stalls.
// The window compare is one parallel stage between the input and result registers.
// Reset clears config to defaults (threshold 31) and all region state; no clearing pass.
// Top level of the fuzzy signature scanner.
module fuzzy_signature_scan (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_write,
    input  logic [fss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fss_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic in_valid,
    output logic in_ready,
    input  logic [fss_pkg::BYTE_W-1:0] data_byte,
    input  logic region_end,
    output logic out_valid,
    input  logic out_ready,
    output logic found,
    output logic [fss_pkg::OFFSET_W-1:0] start_offset,
    output logic overflowed
);

    fss_pkg::cfg_t cfg;

    logic s1_valid_reg;
    logic [fss_pkg::BYTE_W-1:0] byte_reg;
    logic last_reg;

    fss_pkg::hist_t window_reg;
    logic [fss_pkg::CNT_W-1:0] seen_reg;
    logic reported_reg;
    logic overflow_reg;

    logic out_valid_reg;
    logic found_reg;
    logic [fss_pkg::OFFSET_W-1:0] offset_reg;
    logic overflowed_reg;

    logic count_hit;
    logic sat;
    logic hit;
    logic miss_end;
    logic has_result;
    logic out_free;
    logic advance;
    logic ovf_now;
    logic [fss_pkg::CNT_W-1:0] start_idx;

    fss_cfg u_cfg (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .cfg(cfg)
    );

    fss_count u_count (
        .window(window_reg),
        .data_byte(byte_reg),
        .cfg(cfg),
        .hit(count_hit)
    );

    assign sat = (seen_reg >= fss_pkg::MAX_REGION_BYTES);
    assign hit = !sat && !reported_reg && (seen_reg >= fss_pkg::FULL_WINDOW_IDX) && count_hit;
    assign miss_end = last_reg && !hit && !reported_reg;
    assign has_result = hit || miss_end;
    assign ovf_now = overflow_reg || sat;
    assign start_idx = seen_reg - fss_pkg::FULL_WINDOW_IDX;

    assign out_free = !out_valid_reg || out_ready;
    assign advance = s1_valid_reg && (!has_result || out_free);
    assign in_ready = !s1_valid_reg || advance;

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= data_byte;
            last_reg <= region_end;
        end
    end

    // region state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            reported_reg <= 1'b0;
            overflow_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (last_reg)
            begin
                seen_reg <= '0;
                reported_reg <= 1'b0;
                overflow_reg <= 1'b0;
            end
            else
            begin
                if (!sat)
                begin
                    seen_reg <= seen_reg + fss_pkg::CNT_W'(1);
                end
                overflow_reg <= ovf_now;
                reported_reg <= reported_reg || hit;
            end
        end
    end

    // history needs no clearing: no compare before a full window of the region
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            window_reg <= {window_reg[fss_pkg::HIST_DEPTH-2:0], byte_reg};
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            found_reg <= hit;
            offset_reg <= hit ? start_idx[fss_pkg::OFFSET_W-1:0] : '0;
            overflowed_reg <= ovf_now;
        end
    end

    assign out_valid = out_valid_reg;
    assign found = found_reg;
    assign start_offset = offset_reg;
    assign overflowed = overflowed_reg;

endmodule
